// File: design/y4m_stream_deframer_unit_macros.svh
// assertion helpers for the deframer unit
`ifndef Y4M_STREAM_DEFRAMER_UNIT_MACROS_SVH
`define Y4M_STREAM_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication, checked at each rising edge outside reset
`define Y4M_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define Y4M_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/y4m_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y4m_pkg
// shared types, character codes and helpers for the y4m stream deframer
// ----------------------------------------------------------------------------
package y4m_pkg;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_HEADER,
        PH_FRAME_MAGIC,
        PH_FRAME_TAGS,
        PH_PAYLOAD
    } phase_t;

    localparam int unsigned CHROMA_TOKEN_LEN = 8;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_STREAM  = 2'd1;
    localparam logic [1:0] KIND_FRAME   = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // chroma codes
    localparam logic [2:0] CHR_420     = 3'd0;
    localparam logic [2:0] CHR_411     = 3'd1;
    localparam logic [2:0] CHR_422     = 3'd2;
    localparam logic [2:0] CHR_444     = 3'd3;
    localparam logic [2:0] CHR_444A    = 3'd4;
    localparam logic [2:0] CHR_MONO    = 3'd5;
    localparam logic [2:0] CHR_UNKNOWN = 3'd6;

    // interlace codes
    localparam logic [1:0] IL_PROG   = 2'd0;
    localparam logic [1:0] IL_TOP    = 2'd1;
    localparam logic [1:0] IL_BOTTOM = 2'd2;
    localparam logic [1:0] IL_MIXED  = 2'd3;

    localparam logic [7:0] MAGIC_TXT [0:8] = '{"Y", "U", "V", "4", "M", "P", "E", "G", "2"};
    localparam logic [7:0] FRAME_TXT [0:4] = '{"F", "R", "A", "M", "E"};

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [30:0] NUM_CAP = 31'h7FFF_FFFF;
    localparam logic [30:0] DIM_CAP = 31'h0000_FFFF;

    // decimal accumulate with saturation at cap
    function automatic logic [30:0] acc_dec(input logic [30:0] acc, input logic [3:0] d,
                                            input logic [30:0] cap);
        logic [34:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, d};
        if (v > {4'd0, cap})
            return cap;
        else
            return v[30:0];
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

endpackage

// File: design/y4m_stream_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y4m_stream_deframer_unit
// yuv4mpeg2 byte stream deframer: header and frame line parsing, payload pass
// ----------------------------------------------------------------------------
// takes one stream byte per cycle and answers with at most one registered
// result item per byte; a new byte is taken every cycle unless a finished
// result is held by a stalled output. the stream header yields one kind 1
// item with width, height, chroma, interlace, rate and aspect; each FRAME
// line yields a kind 2 item, then every payload byte a kind 0 item with pts
// and a last flag. frame size is worked out behind the header (multiply,
// then combine), well before any frame line can end. any error gives kind 3
// on that byte and on every later one until reset.
module y4m_stream_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  byte_out,
    output logic        last_of_frame,
    output logic [15:0] width,
    output logic [15:0] height,
    output logic [2:0]  chroma,
    output logic [1:0]  interlace,
    output logic [31:0] time_scale,
    output logic [35:0] duration,
    output logic [62:0] pts,
    output logic [30:0] aspect_num,
    output logic [30:0] aspect_den
);

    // parser state
    y4m_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  mi_reg, mi_next;          // match index
    logic [7:0]  tag_reg, tag_next;        // current tag letter
    logic        intok_reg, intok_next;
    logic [30:0] acc_reg, acc_next;
    logic [30:0] first_reg, first_next;
    logic [3:0]  clen_reg, clen_next;      // chroma token length, saturates one past the store
    logic        cseen_reg, cseen_next;
    logic [7:0]  ctok_mem [0:y4m_pkg::CHROMA_TOKEN_LEN-1];
    logic        ctok_we;
    logic [2:0]  ctok_addr;

    // stream attributes
    logic [15:0] w_reg, w_next;
    logic [15:0] h_reg, h_next;
    logic [2:0]  chr_reg, chr_next;
    logic [1:0]  il_reg, il_next;
    logic [31:0] ts_reg, ts_next;
    logic [32:0] sd_reg, sd_next;
    logic [30:0] an_reg, an_next;
    logic [30:0] ad_reg, ad_next;

    // frame tracking
    logic [33:0] fsize_reg;
    logic [33:0] bl_reg, bl_next;          // bytes left
    logic [35:0] fd_reg, fd_next;          // this frame's duration
    logic [62:0] pts_reg, pts_next;
    logic        err_reg, err_next;

    // frame size pipe: stage 0 multiplies, stage 1 combines
    logic [1:0]  size_pipe_reg;
    logic        size_start;
    logic [31:0] prod_a_reg, prod_b_reg;
    logic [15:0] op_b1, op_b2;

    // events of the byte in hand
    logic        in_fire;
    logic        ev_err, ev_hdr, ev_frm, ev_pay, ev_last;
    logic        dig;
    logic [33:0] bl_dec;
    logic [34:0] d3;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  kind_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [15:0] wo_reg, ho_reg;
    logic [2:0]  co_reg;
    logic [1:0]  io_reg;
    logic [31:0] tso_reg;
    logic [35:0] dur_reg;
    logic [62:0] ptso_reg;
    logic [30:0] ano_reg, ado_reg;
    logic        load_out;
    logic [1:0]  kind_next;
    logic [35:0] dur_next;

    // the input waits only while a finished item is held downstream
    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;
    assign dig      = (byte_in >= "0") && (byte_in <= "9");
    assign bl_dec   = (bl_reg != 34'd0) ? bl_reg - 34'd1 : bl_reg;
    assign d3       = {2'b00, sd_reg} + {1'b0, sd_reg, 1'b0};

    // next state of the parser and stream attributes
    always_comb
    begin
        phase_next = phase_reg;
        mi_next    = mi_reg;
        tag_next   = tag_reg;
        intok_next = intok_reg;
        acc_next   = acc_reg;
        first_next = first_reg;
        clen_next  = clen_reg;
        cseen_next = cseen_reg;
        ctok_we    = 1'b0;
        ctok_addr  = clen_reg[2:0];
        w_next     = w_reg;
        h_next     = h_reg;
        chr_next   = chr_reg;
        il_next    = il_reg;
        ts_next    = ts_reg;
        sd_next    = sd_reg;
        an_next    = an_reg;
        ad_next    = ad_reg;
        bl_next    = bl_reg;
        fd_next    = fd_reg;
        pts_next   = pts_reg;
        err_next   = err_reg;
        size_start = 1'b0;
        ev_err     = 1'b0;
        ev_hdr     = 1'b0;
        ev_frm     = 1'b0;
        ev_pay     = 1'b0;
        ev_last    = 1'b0;

        if (in_fire)
        begin
            if (err_reg)
            begin
                ev_err = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    y4m_pkg::PH_MAGIC:
                    begin
                        if (mi_reg < 4'd9 && byte_in == y4m_pkg::MAGIC_TXT[mi_reg])
                        begin
                            mi_next = mi_reg + 4'd1;
                            if (mi_reg == 4'd8)
                            begin
                                phase_next = y4m_pkg::PH_HEADER;
                                intok_next = 1'b1;
                                tag_next   = 8'd0;
                                mi_next    = 4'd0;
                            end
                        end
                        else
                        begin
                            err_next = 1'b1;
                            ev_err   = 1'b1;
                        end
                    end

                    y4m_pkg::PH_HEADER:
                    begin
                        if (y4m_pkg::is_ws(byte_in))
                        begin
                            // token end
                            if (intok_reg)
                            begin
                                case (tag_reg)
                                    "W": w_next = acc_reg[15:0];
                                    "H": h_next = acc_reg[15:0];
                                    "F":
                                    begin
                                        if (mi_reg < 4'd3)
                                            err_next = 1'b1;
                                        else
                                        begin
                                            ts_next = {1'b0, first_reg};
                                            sd_next = {2'b00, acc_reg};
                                        end
                                    end
                                    "A":
                                    begin
                                        if (mi_reg < 4'd3)
                                            err_next = 1'b1;
                                        else
                                        begin
                                            an_next = first_reg;
                                            ad_next = acc_reg;
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                            intok_next = 1'b0;
                            if (err_next)
                                ev_err = 1'b1;
                            else if (byte_in == y4m_pkg::CH_LF)
                            begin
                                // header finish: defaults, mixed doubling, chroma
                                if (ts_next == 32'd0 || sd_next == 33'd0)
                                begin
                                    ts_next = 32'd25;
                                    sd_next = 33'd1;
                                end
                                if (an_next == 31'd0 || ad_next == 31'd0)
                                begin
                                    an_next = 31'd1;
                                    ad_next = 31'd1;
                                end
                                if (il_reg == y4m_pkg::IL_MIXED)
                                begin
                                    ts_next = {ts_next[30:0], 1'b0};
                                    sd_next = {sd_next[31:0], 1'b0};
                                end
                                if (!cseen_reg)
                                    chr_next = y4m_pkg::CHR_420;
                                else if (clen_reg >= 4'd3 && ctok_mem[0] == "4"
                                         && ctok_mem[1] == "2" && ctok_mem[2] == "0")
                                    chr_next = y4m_pkg::CHR_420;
                                else if (clen_reg == 4'd3 && ctok_mem[0] == "4"
                                         && ctok_mem[1] == "1" && ctok_mem[2] == "1")
                                    chr_next = y4m_pkg::CHR_411;
                                else if (clen_reg == 4'd3 && ctok_mem[0] == "4"
                                         && ctok_mem[1] == "2" && ctok_mem[2] == "2")
                                    chr_next = y4m_pkg::CHR_422;
                                else if (clen_reg == 4'd3 && ctok_mem[0] == "4"
                                         && ctok_mem[1] == "4" && ctok_mem[2] == "4")
                                    chr_next = y4m_pkg::CHR_444;
                                else if (clen_reg == 4'd8 && ctok_mem[0] == "4"
                                         && ctok_mem[1] == "4" && ctok_mem[2] == "4"
                                         && ctok_mem[3] == "a" && ctok_mem[4] == "l"
                                         && ctok_mem[5] == "p" && ctok_mem[6] == "h"
                                         && ctok_mem[7] == "a")
                                    chr_next = y4m_pkg::CHR_444A;
                                else if (clen_reg == 4'd4 && ctok_mem[0] == "m"
                                         && ctok_mem[1] == "o" && ctok_mem[2] == "n"
                                         && ctok_mem[3] == "o")
                                    chr_next = y4m_pkg::CHR_MONO;
                                else
                                    chr_next = y4m_pkg::CHR_UNKNOWN;
                                size_start = 1'b1;
                                ev_hdr     = 1'b1;
                                phase_next = y4m_pkg::PH_FRAME_MAGIC;
                                mi_next    = 4'd0;
                            end
                        end
                        else if (!intok_reg)
                        begin
                            intok_next = 1'b1;
                            tag_next   = byte_in;
                            mi_next    = 4'd0;
                            acc_next   = 31'd0;
                            first_next = 31'd0;
                            if (byte_in == "C")
                            begin
                                cseen_next = 1'b1;
                                clen_next  = 4'd0;
                            end
                        end
                        else
                        begin
                            case (tag_reg)
                                "W", "H":
                                begin
                                    if (mi_reg == 4'd0)
                                    begin
                                        if (dig)
                                            acc_next = y4m_pkg::acc_dec(acc_reg, byte_in[3:0],
                                                                        y4m_pkg::DIM_CAP);
                                        else
                                            mi_next = 4'd1;
                                    end
                                end
                                "I":
                                begin
                                    if (mi_reg == 4'd0)
                                    begin
                                        if (byte_in == "p" || byte_in == "?")
                                            il_next = y4m_pkg::IL_PROG;
                                        else if (byte_in == "t")
                                            il_next = y4m_pkg::IL_TOP;
                                        else if (byte_in == "b")
                                            il_next = y4m_pkg::IL_BOTTOM;
                                        else if (byte_in == "m")
                                            il_next = y4m_pkg::IL_MIXED;
                                        mi_next = 4'd1;
                                    end
                                end
                                "C":
                                begin
                                    if (clen_reg < 4'd8)
                                        ctok_we = 1'b1;
                                    if (clen_reg <= 4'd8)
                                        clen_next = clen_reg + 4'd1;
                                end
                                "F", "A":
                                begin
                                    if (mi_reg == 4'd0 || mi_reg == 4'd2)
                                    begin
                                        if (dig)
                                        begin
                                            acc_next = y4m_pkg::acc_dec(acc_reg, byte_in[3:0],
                                                                        y4m_pkg::NUM_CAP);
                                            mi_next  = mi_reg + 4'd1;
                                        end
                                        else
                                            err_next = 1'b1;
                                    end
                                    else if (mi_reg == 4'd1)
                                    begin
                                        if (dig)
                                            acc_next = y4m_pkg::acc_dec(acc_reg, byte_in[3:0],
                                                                        y4m_pkg::NUM_CAP);
                                        else if (byte_in == ":")
                                        begin
                                            first_next = acc_reg;
                                            acc_next   = 31'd0;
                                            mi_next    = 4'd2;
                                        end
                                        else
                                            err_next = 1'b1;
                                    end
                                    else if (mi_reg == 4'd3)
                                    begin
                                        if (dig)
                                            acc_next = y4m_pkg::acc_dec(acc_reg, byte_in[3:0],
                                                                        y4m_pkg::NUM_CAP);
                                        else
                                            mi_next = 4'd4;
                                    end
                                end
                                default: ;
                            endcase
                            if (err_next)
                                ev_err = 1'b1;
                        end
                    end

                    y4m_pkg::PH_FRAME_MAGIC:
                    begin
                        if (mi_reg < 4'd5 && byte_in == y4m_pkg::FRAME_TXT[mi_reg[2:0]])
                        begin
                            mi_next = mi_reg + 4'd1;
                            if (mi_reg == 4'd4)
                            begin
                                phase_next = y4m_pkg::PH_FRAME_TAGS;
                                intok_next = 1'b1;
                                tag_next   = 8'd0;
                                mi_next    = 4'd0;
                                fd_next    = {3'd0, sd_reg};
                            end
                        end
                        else
                        begin
                            err_next = 1'b1;
                            ev_err   = 1'b1;
                        end
                    end

                    y4m_pkg::PH_FRAME_TAGS:
                    begin
                        if (y4m_pkg::is_ws(byte_in))
                        begin
                            intok_next = 1'b0;
                            if (byte_in == y4m_pkg::CH_LF)
                            begin
                                ev_frm = 1'b1;
                                if (fsize_reg == 34'd0)
                                begin
                                    ev_last    = 1'b1;
                                    pts_next   = pts_reg + {27'd0, fd_reg};
                                    phase_next = y4m_pkg::PH_FRAME_MAGIC;
                                    mi_next    = 4'd0;
                                end
                                else
                                begin
                                    bl_next    = fsize_reg;
                                    phase_next = y4m_pkg::PH_PAYLOAD;
                                end
                            end
                        end
                        else if (!intok_reg)
                        begin
                            intok_next = 1'b1;
                            tag_next   = byte_in;
                            mi_next    = 4'd0;
                            acc_next   = 31'd0;
                            first_next = 31'd0;
                        end
                        else if (tag_reg == "I" && mi_reg == 4'd0)
                        begin
                            if (byte_in == "t" || byte_in == "b" || byte_in == "1")
                                fd_next = {3'd0, sd_reg};
                            else if (byte_in == "T" || byte_in == "B")
                                fd_next = {2'd0, d3[34:1]};
                            else if (byte_in == "2")
                                fd_next = {2'd0, sd_reg, 1'b0};
                            else if (byte_in == "3")
                                fd_next = {1'b0, d3};
                            mi_next = 4'd1;
                        end
                    end

                    y4m_pkg::PH_PAYLOAD:
                    begin
                        bl_next = bl_dec;
                        ev_pay  = 1'b1;
                        if (bl_dec == 34'd0)
                        begin
                            ev_last    = 1'b1;
                            pts_next   = pts_reg + {27'd0, fd_reg};
                            phase_next = y4m_pkg::PH_FRAME_MAGIC;
                            mi_next    = 4'd0;
                        end
                    end

                    default:
                    begin
                        err_next = 1'b1;
                        ev_err   = 1'b1;
                    end
                endcase
            end
        end
    end

    // result item formation
    always_comb
    begin
        load_out  = ev_err || ev_hdr || ev_frm || ev_pay;
        kind_next = y4m_pkg::KIND_ERROR;
        dur_next  = fd_reg;
        if (ev_pay)
            kind_next = y4m_pkg::KIND_PAYLOAD;
        else if (ev_hdr)
        begin
            kind_next = y4m_pkg::KIND_STREAM;
            dur_next  = {3'd0, sd_next};
        end
        else if (ev_frm)
            kind_next = y4m_pkg::KIND_FRAME;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    // frame size operands by chroma layout
    always_comb
    begin
        case (chr_reg)
            y4m_pkg::CHR_420:
            begin
                op_b1 = {1'b0, w_reg[15:1]};
                op_b2 = {1'b0, h_reg[15:1]};
            end
            y4m_pkg::CHR_411:
            begin
                op_b1 = {2'b00, w_reg[15:2]};
                op_b2 = h_reg;
            end
            y4m_pkg::CHR_422:
            begin
                op_b1 = {1'b0, w_reg[15:1]};
                op_b2 = h_reg;
            end
            default:
            begin
                op_b1 = 16'd0;
                op_b2 = 16'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (size_pipe_reg[0])
        begin
            prod_a_reg <= w_reg * h_reg;
            prod_b_reg <= op_b1 * op_b2;
        end
    end

    // chroma token store, no reset
    always_ff @(posedge clk)
    begin
        if (ctok_we)
            ctok_mem[ctok_addr] <= byte_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= y4m_pkg::PH_MAGIC;
            mi_reg        <= 4'd0;
            tag_reg       <= 8'd0;
            intok_reg     <= 1'b0;
            acc_reg       <= 31'd0;
            first_reg     <= 31'd0;
            clen_reg      <= 4'd0;
            cseen_reg     <= 1'b0;
            w_reg         <= 16'd0;
            h_reg         <= 16'd0;
            chr_reg       <= y4m_pkg::CHR_420;
            il_reg        <= y4m_pkg::IL_PROG;
            ts_reg        <= 32'd0;
            sd_reg        <= 33'd0;
            an_reg        <= 31'd0;
            ad_reg        <= 31'd0;
            fsize_reg     <= 34'd0;
            bl_reg        <= 34'd0;
            fd_reg        <= 36'd0;
            pts_reg       <= 63'd0;
            err_reg       <= 1'b0;
            size_pipe_reg <= 2'b00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            mi_reg        <= mi_next;
            tag_reg       <= tag_next;
            intok_reg     <= intok_next;
            acc_reg       <= acc_next;
            first_reg     <= first_next;
            clen_reg      <= clen_next;
            cseen_reg     <= cseen_next;
            w_reg         <= w_next;
            h_reg         <= h_next;
            chr_reg       <= chr_next;
            il_reg        <= il_next;
            ts_reg        <= ts_next;
            sd_reg        <= sd_next;
            an_reg        <= an_next;
            ad_reg        <= ad_next;
            bl_reg        <= bl_next;
            fd_reg        <= fd_next;
            pts_reg       <= pts_next;
            err_reg       <= err_next;
            size_pipe_reg <= {size_pipe_reg[0], size_start};
            out_valid_reg <= out_valid_next;
            if (size_pipe_reg[1])
            begin
                case (chr_reg)
                    y4m_pkg::CHR_420, y4m_pkg::CHR_411, y4m_pkg::CHR_422:
                        fsize_reg <= {2'b00, prod_a_reg} + {1'b0, prod_b_reg, 1'b0};
                    y4m_pkg::CHR_444:
                        fsize_reg <= {2'b00, prod_a_reg} + {1'b0, prod_a_reg, 1'b0};
                    y4m_pkg::CHR_444A:
                        fsize_reg <= {prod_a_reg, 2'b00};
                    y4m_pkg::CHR_MONO:
                        fsize_reg <= {2'b00, prod_a_reg};
                    default:
                        fsize_reg <= 34'd0;
                endcase
            end
        end
    end

    // result payload, no reset needed; error items carry zeros
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            kind_reg <= kind_next;
            if (ev_err)
            begin
                byte_reg <= 8'd0;
                last_reg <= 1'b0;
                wo_reg   <= 16'd0;
                ho_reg   <= 16'd0;
                co_reg   <= 3'd0;
                io_reg   <= 2'd0;
                tso_reg  <= 32'd0;
                dur_reg  <= 36'd0;
                ptso_reg <= 63'd0;
                ano_reg  <= 31'd0;
                ado_reg  <= 31'd0;
            end
            else
            begin
                byte_reg <= ev_pay ? byte_in : 8'd0;
                last_reg <= ev_last;
                wo_reg   <= w_next;
                ho_reg   <= h_next;
                co_reg   <= chr_next;
                io_reg   <= il_next;
                tso_reg  <= ts_next;
                dur_reg  <= dur_next;
                ptso_reg <= pts_reg;
                ano_reg  <= an_next;
                ado_reg  <= ad_next;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign byte_out      = byte_reg;
    assign last_of_frame = last_reg;
    assign width         = wo_reg;
    assign height        = ho_reg;
    assign chroma        = co_reg;
    assign interlace     = io_reg;
    assign time_scale    = tso_reg;
    assign duration      = dur_reg;
    assign pts           = ptso_reg;
    assign aspect_num    = ano_reg;
    assign aspect_den    = ado_reg;

`include "y4m_stream_deframer_unit_macros.svh"

    `Y4M_ASSERT_NOW(a_size_ready, ev_frm, size_pipe_reg == 2'b00, "frame size not settled at frame line end")
    `Y4M_ASSERT_NEXT(a_err_sticky, err_reg, err_reg, "error flag cleared without reset")
    `Y4M_ASSERT_NOW(a_payload_left, phase_reg == y4m_pkg::PH_PAYLOAD, bl_reg != 34'd0, "payload phase with no bytes left")
    `Y4M_ASSERT_NOW(a_err_zero, out_valid_reg && kind_reg == y4m_pkg::KIND_ERROR, ptso_reg == 63'd0 && dur_reg == 36'd0, "error item carries data")

endmodule
